FILE: hw/rtl/plp_pkg.sv
`timescale 1ns / 1ps

package plp_pkg;

    localparam int MAX_ENTRIES_W = 11;
    localparam int ENTRY_W       = 10;

    localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RESET = 11'd1024;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } plp_in_t;

    typedef struct packed {
        logic [7:0]         path_char;
        logic [ENTRY_W-1:0] entry_number;
        logic               path_end;
    } plp_out_t;

endpackage

FILE: hw/rtl/plp_line_ram.sv
`timescale 1ns / 1ps

module plp_line_ram #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/playlist_line_parser.sv
`timescale 1ns / 1ps

// Streaming playlist line parser. Text bytes come in on the s_ side, one per
// request. CR, LF or the byte marked end_of_text ends a line; the trimmed
// line (leading and trailing spaces and tabs removed, at most LINE_BYTES-1
// bytes, comment and blank lines dropped) is then sent on the m_ side one
// byte per request, tagged with its entry number and a mark on its last
// byte. While a line is being sent the input is held off: each path byte
// takes a line store read and then a load of the output register, which
// waits while that register holds a byte m_ready has not taken. Once
// max_entries paths have gone out, bytes are consumed with no output until
// end_of_text restarts the count. max_entries is written via cfg_wr_en.
module playlist_line_parser
    import plp_pkg::*;
#(
    parameter int LINE_BYTES = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [MAX_ENTRIES_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  plp_in_t                  s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output plp_out_t                 m_data
);

    localparam int KEEP = LINE_BYTES - 1;
    localparam int LW   = $clog2(LINE_BYTES);
    localparam int IW   = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam logic [LW-1:0] KEEP_LEN = LW'(KEEP);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    state_t                   state_reg;
    logic [MAX_ENTRIES_W-1:0] max_entries_reg;
    logic [MAX_ENTRIES_W-1:0] paths_reg, paths_next;
    logic [LW-1:0]            stored_reg, stored_next;
    logic [LW-1:0]            trimmed_reg, trimmed_next;
    logic                     started_reg, started_next;
    logic                     comment_reg, comment_next;
    logic [LW-1:0]            emit_len_reg;
    logic [LW-1:0]            emit_idx_reg;
    logic [ENTRY_W-1:0]       entry_reg;
    logic                     m_valid_reg;
    plp_out_t                 m_data_reg;

    logic       accept;
    logic       under_limit;
    logic       is_term;
    logic       is_blank;
    logic       flush;
    logic       emit;
    logic       mem_we;
    logic [7:0] rd_data;
    logic [LW-1:0] line_trim;
    logic       line_started;
    logic       line_comment;
    logic       out_free;
    logic       last_byte;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign last_byte = (emit_idx_reg + LW'(1)) == emit_len_reg;

    assign under_limit = paths_reg < max_entries_reg;
    assign is_term  = (s_data.text_byte == CHAR_LF) || (s_data.text_byte == CHAR_CR);
    assign is_blank = (s_data.text_byte == CHAR_SPACE) || (s_data.text_byte == CHAR_TAB);

    always_comb begin
        line_started = started_reg;
        line_comment = comment_reg;
        line_trim    = trimmed_reg;
        stored_next  = stored_reg;
        mem_we       = 1'b0;
        if (under_limit && !is_term && !comment_reg) begin
            if (!started_reg && !is_blank) begin
                line_started = 1'b1;
                line_comment = (s_data.text_byte == CHAR_HASH) ||
                               (s_data.text_byte == CHAR_SEMI);
            end
            if (line_started && !line_comment) begin
                if (stored_reg < KEEP_LEN) begin
                    mem_we      = accept;
                    stored_next = stored_reg + LW'(1);
                end
                if (!is_blank) begin
                    // saturates once the store is full
                    line_trim = (stored_reg < KEEP_LEN) ? stored_reg + LW'(1) : KEEP_LEN;
                end
            end
        end

        flush = under_limit && (is_term || s_data.end_of_text);
        emit  = flush && !line_comment && (line_trim != '0);

        started_next = line_started;
        comment_next = line_comment;
        trimmed_next = line_trim;
        paths_next   = emit ? paths_reg + MAX_ENTRIES_W'(1) : paths_reg;
        if (flush || s_data.end_of_text) begin
            started_next = 1'b0;
            comment_next = 1'b0;
            trimmed_next = '0;
            stored_next  = '0;
        end
        if (s_data.end_of_text) begin
            paths_next = '0;
        end
    end

    plp_line_ram #(
        .DEPTH(KEEP),
        .AW   (IW)
    ) u_line_ram (
        .aclk   (aclk),
        .wr_en  (mem_we),
        .wr_addr(stored_reg[IW-1:0]),
        .wr_data(s_data.text_byte),
        .rd_en  (state_reg == S_READ),
        .rd_addr(emit_idx_reg[IW-1:0]),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end else if (cfg_wr_en) begin
            max_entries_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paths_reg   <= '0;
            stored_reg  <= '0;
            trimmed_reg <= '0;
            started_reg <= 1'b0;
            comment_reg <= 1'b0;
        end else if (accept) begin
            paths_reg   <= paths_next;
            stored_reg  <= stored_next;
            trimmed_reg <= trimmed_next;
            started_reg <= started_next;
            comment_reg <= comment_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            emit_idx_reg <= '0;
        end else begin
            // the load state drives valid itself
            if (m_valid_reg && m_ready && state_reg != S_LOAD) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept && emit) begin
                        emit_len_reg <= line_trim;
                        emit_idx_reg <= '0;
                        entry_reg    <= paths_reg[ENTRY_W-1:0];
                        state_reg    <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    // read data holds until the output register frees up
                    if (out_free) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.path_char    <= rd_data;
                        m_data_reg.entry_number <= entry_reg;
                        m_data_reg.path_end     <= last_byte;
                        emit_idx_reg            <= emit_idx_reg + LW'(1);
                        state_reg               <= last_byte ? S_IDLE : S_READ;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: tb/playlist_line_parser_test.sv
`timescale 1ns / 1ps

module playlist_line_parser_test;
    import plp_pkg::*;

    localparam int LINE_BYTES  = 64;
    localparam int KEEP        = LINE_BYTES - 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_REQS = 270;
    localparam int LONG_HOLD   = 400;

    // tracks the line being parsed and the path bytes it should produce
    class path_tracker;
        logic [7:0]  line_buf [KEEP];
        int unsigned kept_len;
        int unsigned trim_len;
        bit          started;
        bit          is_comment;
        logic [10:0] emitted;
        logic [10:0] limit;
        plp_out_t    expected_chars [$];
        int unsigned errors;

        function new();
            kept_len   = 0;
            trim_len   = 0;
            started    = 0;
            is_comment = 0;
            emitted    = '0;
            limit      = MAX_ENTRIES_RESET;
            errors     = 0;
        endfunction

        function void clear_line();
            kept_len   = 0;
            trim_len   = 0;
            started    = 0;
            is_comment = 0;
        endfunction

        // returns 1 when the request was still inside the entry limit
        function bit take_byte(plp_in_t req);
            logic [7:0] c;
            bit         eol;
            bit         blank;
            bit         active;
            plp_out_t   item;
            c      = req.text_byte;
            eol    = (c == CHAR_LF) || (c == CHAR_CR);
            blank  = (c == CHAR_SPACE) || (c == CHAR_TAB);
            active = (emitted < limit);
            if (active) begin
                if (!eol && !is_comment) begin
                    if (!started && !blank) begin
                        started = 1;
                        if (c == CHAR_HASH || c == CHAR_SEMI)
                            is_comment = 1;
                    end
                    if (started && !is_comment) begin
                        if (!blank)
                            trim_len = (kept_len + 1 < KEEP) ? kept_len + 1 : KEEP;
                        if (kept_len < KEEP) begin
                            line_buf[kept_len] = c;
                            kept_len++;
                        end
                    end
                end
                if (eol || req.end_of_text) begin
                    if (!is_comment && trim_len > 0) begin
                        for (int k = 0; k < trim_len; k++) begin
                            item.path_char    = line_buf[k];
                            item.entry_number = emitted[ENTRY_W-1:0];
                            item.path_end     = (k + 1 == trim_len);
                            expected_chars.push_back(item);
                        end
                        emitted = emitted + 11'd1;
                    end
                    clear_line();
                end
            end
            if (req.end_of_text) begin
                clear_line();
                emitted = '0;
            end
            return active;
        endfunction

        function void check_char(plp_out_t got);
            plp_out_t want;
            if (expected_chars.size() == 0) begin
                $error("path byte %h (entry %0d) with nothing expected",
                       got.path_char, got.entry_number);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.path_char !== want.path_char) begin
                $error("path_char expected %h got %h", want.path_char, got.path_char);
                errors++;
            end
            if (got.entry_number !== want.entry_number) begin
                $error("entry_number expected %0d got %0d",
                       want.entry_number, got.entry_number);
                errors++;
            end
            if (got.path_end !== want.path_end) begin
                $error("path_end expected %b got %b", want.path_end, got.path_end);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [MAX_ENTRIES_W-1:0] cfg_wr_data = '0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    plp_in_t                  s_data      = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    plp_out_t                 m_data;

    path_tracker tracker = new();

    int unsigned tx_streak      = 0;
    int unsigned rx_streak      = 0;
    int unsigned rx_wait        = 0;
    int unsigned sent_reqs      = 0;
    int          cycle_count    = 0;
    bit          long_hold_req  = 0;

    always #5 aclk = ~aclk;

    playlist_line_parser #(
        .LINE_BYTES(LINE_BYTES)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // mostly random gaps, with occasional runs of back-to-back requests
    function automatic int unsigned pick_gap(inout int unsigned streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            streak = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    function automatic logic [7:0] letter_byte();
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // anything but a line terminator
    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1))
            b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == CHAR_LF || b == CHAR_CR)
            b = CHAR_SPACE;
        return b;
    endfunction

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("playlist_line_parser_test: errors");
            $finish;
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                tracker.check_char(m_data);
                rx_wait = pick_gap(rx_streak);
            end
            if (long_hold_req) begin
                long_hold_req = 0;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int unsigned gap;
        gap = pick_gap(tx_streak);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{text_byte: b, end_of_text: eot};
        do @(posedge aclk); while (!s_ready);
        void'(tracker.take_byte(s_data));
        sent_reqs++;
    endtask

    task automatic send_text(input string txt, input bit close_text);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], close_text && (i == txt.len() - 1));
    endtask

    // one line of random shape; close_text puts end_of_text on its last byte
    task automatic send_line(input bit close_text, input bit want_long);
        logic [7:0]  body [$];
        int unsigned kind;
        int unsigned ending;
        kind = want_long ? 3 : $urandom_range(0, 15);
        repeat ($urandom_range(0, 2)) body.push_back(blank_byte());
        case (kind)
            0: ;
            1: begin
                body.push_back($urandom_range(0, 1) ? CHAR_HASH : CHAR_SEMI);
                repeat ($urandom_range(0, 6)) body.push_back(any_text_byte());
            end
            2: begin
                // raw noise, terminators included
                repeat ($urandom_range(1, 6)) body.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
                body.push_back(letter_byte());
                repeat ($urandom_range(60, 80)) body.push_back(any_text_byte());
            end
            default: begin
                body.push_back(letter_byte());
                repeat ($urandom_range(0, 9)) body.push_back(any_text_byte());
            end
        endcase
        if (kind != 2)
            repeat ($urandom_range(0, 2)) body.push_back(blank_byte());
        ending = $urandom_range(0, 3);
        if (ending == 0 && !(close_text && body.size() > 0))
            ending = 1;
        case (ending)
            1: body.push_back(CHAR_LF);
            2: body.push_back(CHAR_CR);
            3: begin
                body.push_back(CHAR_CR);
                body.push_back(CHAR_LF);
            end
            default: ;
        endcase
        for (int i = 0; i < body.size(); i++)
            send_byte(body[i], close_text && (i == body.size() - 1));
    endtask

    // block idle: every expected byte back and the last request fully absorbed
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.expected_chars.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [MAX_ENTRIES_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        tracker.limit = v;
    endtask

    initial begin
        int unsigned              phase;
        int unsigned              n_lines;
        logic [MAX_ENTRIES_W-1:0] lim;
        bit                       close_it;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // blanks around and inside a path, CR LF ending
        send_text(" \tA b\t \r\n", 0);
        send_text("#x\n", 0);
        send_text(" ;y\r", 0);
        // zero and all-ones bytes are plain path bytes
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_byte(CHAR_LF, 0);
        // end of text on an ordinary byte flushes the line
        send_text("q", 1);
        sent_reqs = 0;

        phase = 0;
        while (sent_reqs < RANDOM_REQS) begin
            wait_idle();
            case (phase)
                0: lim = '0;
                1: lim = MAX_ENTRIES_RESET;
                2: lim = 11'd1;
                default: begin
                    case ($urandom_range(0, 5))
                        0: lim = '0;
                        1: lim = 11'd1;
                        2: lim = 11'($urandom_range(2, 4));
                        3: lim = 11'($urandom_range(1, 1024));
                        default: lim = MAX_ENTRIES_RESET;
                    endcase
                end
            endcase
            write_limit(lim);
            n_lines = $urandom_range(4, 10);
            if (phase == 1) begin
                // receiver stalls while long paths pile up behind it
                long_hold_req = 1;
                send_line(0, 1);
                send_line(0, 1);
            end
            for (int i = 0; i < n_lines; i++) begin
                // phase 1 leaves its text open so that phase 2 lowers the limit mid-text
                close_it = (i == n_lines - 1) && (phase != 1) && ($urandom_range(0, 1) == 1);
                send_line(close_it, 0);
            end
            phase++;
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_chars.size() == 0)
            $display("playlist_line_parser_test: clean");
        else
            $display("playlist_line_parser_test: errors");
        $finish;
    end

endmodule
